// ----- hdl/tsb_pkg.sv -----
// Shared types, codes and tables for the two-layer sprite blitter.
// No dependencies. Used by tsb_pixel_gen and two_layer_sprite_blitter_top, and by the checker and testbench.
package tsb_pkg;

	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;

	localparam logic [2:0] FN_PLOT  = 3'd0;
	localparam logic [2:0] FN_BLIT  = 3'd1;
	localparam logic [2:0] FN_CLEAR = 3'd2;
	localparam logic [2:0] FN_READ  = 3'd3;
	localparam logic [2:0] FN_ACK   = 3'd4;

	localparam logic [2:0] CFG_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_RED    = 3'd2;
	localparam logic [2:0] CFG_GREEN  = 3'd3;
	localparam logic [2:0] CFG_BLUE   = 3'd4;

	typedef struct packed {
		logic [2:0]  func;
		logic        layer_select;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [63:0] sprite_plane_low;
		logic [63:0] sprite_plane_high;
		logic [3:0]  color;
		logic        flip_x;
		logic        flip_y;
		logic        two_bpp;
	} req_t;

	typedef struct packed {
		logic [3:0]  composed_index;
		logic [11:0] pixel_rgb;
		logic        fg_changed;
		logic        bg_changed;
	} rsp_t;

	typedef struct packed {
		logic       paint;
		logic       onscreen;
		logic [1:0] val;
	} pix_t;

	localparam logic [1:0] BLEND_TAB [5][16] = '{
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
		  2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
		'{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
		  2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
		  2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
		'{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
		  2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2},
		'{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1,
		  2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}
	};

endpackage

// ----- hdl/tsb_layer_ram.sv -----
// Single-write, single-read layer memory of 2-bit pixels with registered read.
// Depends on nothing.
module tsb_layer_ram #(
	parameter int DEPTH = 262144,
	parameter int AW    = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);

	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/tsb_pixel_gen.sv -----
// Maps one request and a sprite pixel counter to a layer address, value and flags.
// Depends on tsb_pkg.
module tsb_pixel_gen #(
	parameter int AW = 18
) (
	input  tsb_pkg::req_t  req,
	input  logic [5:0]     cnt,
	input  logic [9:0]     w_eff,
	input  logic [9:0]     h_eff,
	output tsb_pkg::pix_t  pix,
	output logic [AW-1:0]  addr
);

	logic [2:0]  row;
	logic [2:0]  col;
	logic [5:0]  bit_idx;
	logic [1:0]  ch;
	logic [15:0] px;
	logic [15:0] py;
	logic [19:0] prod;
	logic [20:0] sum;
	logic        blit;

	always_comb begin
		blit    = (req.func == tsb_pkg::FN_BLIT);
		row     = cnt[5:3];
		col     = cnt[2:0];
		bit_idx = {row, ~col};
		ch      = {req.two_bpp & req.sprite_plane_high[bit_idx], req.sprite_plane_low[bit_idx]};
		if (blit) begin
			px = req.x_pos + {13'd0, req.flip_x ? ~col : col};
			py = req.y_pos + {13'd0, req.flip_y ? ~row : row};
			pix.val   = tsb_pkg::BLEND_TAB[ch][req.color];
			pix.paint = (tsb_pkg::BLEND_TAB[4][req.color] != 2'd0) || (ch != 2'd0);
		end else begin
			px = req.x_pos;
			py = req.y_pos;
			pix.val   = req.color[1:0];
			pix.paint = 1'b1;
		end
		pix.onscreen = (px < {6'd0, w_eff}) && (py < {6'd0, h_eff});
		prod = py[9:0] * w_eff;
		sum  = {1'b0, prod} + {11'd0, px[9:0]};
		addr = AW'(sum);
	end

endmodule

// ----- hdl/two_layer_sprite_blitter_top.sv -----
// Two-layer 2bpp sprite blitter: plot, blit, clear, read and acknowledge requests.
// Depends on tsb_pkg, tsb_pixel_gen and tsb_layer_ram.
// Plot and read handle one pixel; acknowledge and unused codes make no pixel pass; blit
// takes 64 pixels through one read-modify-write pass of the layer memory; clear zeroes width*height cells.
// One request at a time. After reset a clearing pass over MAX_WIDTH*MAX_HEIGHT cells
// zeroes both layers; no request is taken until it ends, configuration writes are.
module two_layer_sprite_blitter_top #(
	parameter int MAX_WIDTH  = tsb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tsb_pkg::MAX_HEIGHT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  tsb_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output tsb_pkg::rsp_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_GEN, ST_DRAIN, ST_CLEAR, ST_DONE
	} state_t;

	state_t        state_q;
	tsb_pkg::req_t req_q;
	logic [5:0]    cnt_q;
	logic [CW-1:0] sweep_q;
	logic [CW-1:0] sweep_end_q;
	logic          fg_dirty_q;
	logic          bg_dirty_q;
	logic [3:0]    comp_q;
	logic [11:0]   rgb_q;
	logic          out_valid_q;
	tsb_pkg::rsp_t out_q;
	logic [9:0]    width_q;
	logic [9:0]    height_q;
	logic [15:0]   red_q;
	logic [15:0]   green_q;
	logic [15:0]   blue_q;

	logic          vld_s1, wr_s1, rd_s1;
	logic [AW-1:0] addr_s1;
	logic [1:0]    val_s1;
	logic          vld_s2, wr_s2, rd_s2;
	logic [1:0]    val_s2;
	logic [AW-1:0] addr_s2;

	logic [9:0]    w_eff, h_eff;
	logic [19:0]   area;
	tsb_pkg::pix_t pix;
	logic [AW-1:0] pix_addr;
	logic          gen_go, gen_last, in_acc;
	logic [1:0]    fg_rd, bg_rd, sel_rd, ent;
	logic          pix_write;
	logic          fg_we, bg_we;
	logic [AW-1:0] waddr;
	logic [3:0]    lv_r, lv_g, lv_b;

	always_comb begin
		w_eff = ({3'd0, width_q} > 13'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : width_q;
		h_eff = ({3'd0, height_q} > 13'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : height_q;
		area  = w_eff * h_eff;
	end

	tsb_pixel_gen #(.AW(AW)) u_gen (
		.req   (req_q),
		.cnt   (cnt_q),
		.w_eff (w_eff),
		.h_eff (h_eff),
		.pix   (pix),
		.addr  (pix_addr)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign gen_go    = (state_q == ST_GEN);
	assign gen_last  = (req_q.func != tsb_pkg::FN_BLIT) || (cnt_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			wr_s1  <= 1'b0;
			rd_s1  <= 1'b0;
			vld_s2 <= 1'b0;
			wr_s2  <= 1'b0;
			rd_s2  <= 1'b0;
		end else begin
			vld_s1 <= gen_go;
			wr_s1  <= gen_go && (req_q.func != tsb_pkg::FN_READ) && pix.paint && pix.onscreen;
			rd_s1  <= gen_go && (req_q.func == tsb_pkg::FN_READ) && pix.onscreen;
			vld_s2 <= vld_s1;
			wr_s2  <= wr_s1;
			rd_s2  <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= pix_addr;
		val_s1  <= pix.val;
		addr_s2 <= addr_s1;
		val_s2  <= val_s1;
	end

	always_comb begin
		sel_rd    = req_q.layer_select ? fg_rd : bg_rd;
		pix_write = wr_s2 && (sel_rd != val_s2);
		ent       = (fg_rd != 2'd0) ? fg_rd : bg_rd;
		lv_r      = red_q[{~ent, 2'b00} +: 4];
		lv_g      = green_q[{~ent, 2'b00} +: 4];
		lv_b      = blue_q[{~ent, 2'b00} +: 4];
		if (state_q == ST_INIT) begin
			fg_we = 1'b1;
			bg_we = 1'b1;
			waddr = sweep_q[AW-1:0];
		end else if (state_q == ST_CLEAR) begin
			fg_we = req_q.layer_select;
			bg_we = !req_q.layer_select;
			waddr = sweep_q[AW-1:0];
		end else begin
			fg_we = pix_write && req_q.layer_select;
			bg_we = pix_write && !req_q.layer_select;
			waddr = addr_s2;
		end
	end

	tsb_layer_ram #(.DEPTH(DEPTH), .AW(AW)) u_fg (
		.clk   (clk),
		.we    (fg_we),
		.waddr (waddr),
		.wdata ((state_q == ST_INIT || state_q == ST_CLEAR) ? 2'd0 : val_s2),
		.raddr (addr_s1),
		.rdata (fg_rd)
	);

	tsb_layer_ram #(.DEPTH(DEPTH), .AW(AW)) u_bg (
		.clk   (clk),
		.we    (bg_we),
		.waddr (waddr),
		.wdata ((state_q == ST_INIT || state_q == ST_CLEAR) ? 2'd0 : val_s2),
		.raddr (addr_s1),
		.rdata (bg_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			req_q       <= '0;
			sweep_q     <= '0;
			sweep_end_q <= CW'(DEPTH);
			cnt_q       <= '0;
			fg_dirty_q  <= 1'b0;
			bg_dirty_q  <= 1'b0;
			comp_q      <= '0;
			rgb_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			width_q     <= 10'd512;
			height_q    <= 10'd512;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pix_write) begin
				if (req_q.layer_select) begin
					fg_dirty_q <= 1'b1;
				end else begin
					bg_dirty_q <= 1'b1;
				end
			end
			if (rd_s2) begin
				comp_q <= {fg_rd, bg_rd};
				rgb_q  <= {lv_r, lv_g, lv_b};
			end
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (sweep_q + CW'(1) >= sweep_end_q) begin
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end
					sweep_q <= sweep_q + CW'(1);
				end
				ST_IDLE: begin
					if (in_acc) begin
						req_q   <= in_data;
						cnt_q   <= '0;
						sweep_q <= '0;
						comp_q  <= '0;
						rgb_q   <= '0;
						case (in_data.func)
							tsb_pkg::FN_PLOT, tsb_pkg::FN_BLIT, tsb_pkg::FN_READ: begin
								state_q <= ST_GEN;
							end
							tsb_pkg::FN_CLEAR: begin
								sweep_end_q <= CW'(area);
								state_q     <= (area == 20'd0) ? ST_DONE : ST_CLEAR;
								if (in_data.layer_select) begin
									fg_dirty_q <= 1'b1;
								end else begin
									bg_dirty_q <= 1'b1;
								end
							end
							tsb_pkg::FN_ACK: begin
								fg_dirty_q <= 1'b0;
								bg_dirty_q <= 1'b0;
								state_q    <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_GEN: begin
					cnt_q <= cnt_q + 6'd1;
					if (gen_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q          <= 1'b1;
						out_q.composed_index <= comp_q;
						out_q.pixel_rgb      <= rgb_q;
						out_q.fg_changed     <= fg_dirty_q;
						out_q.bg_changed     <= bg_dirty_q;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tsb_pkg::CFG_WIDTH:  width_q  <= cfg_data[9:0];
					tsb_pkg::CFG_HEIGHT: height_q <= cfg_data[9:0];
					tsb_pkg::CFG_RED: begin
						red_q      <= cfg_data;
						fg_dirty_q <= 1'b1;
						bg_dirty_q <= 1'b1;
					end
					tsb_pkg::CFG_GREEN: begin
						green_q    <= cfg_data;
						fg_dirty_q <= 1'b1;
						bg_dirty_q <= 1'b1;
					end
					tsb_pkg::CFG_BLUE: begin
						blue_q     <= cfg_data;
						fg_dirty_q <= 1'b1;
						bg_dirty_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_sweep_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT || state_q == ST_CLEAR) |-> !vld_s2)
		else $error("pixel pass overlaps a clearing pass");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (!vld_s1 && !vld_s2))
		else $error("request accepted while pixels are in flight");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result issued outside completion");

endmodule

// ----- verif/two_layer_sprite_blitter_checker.sv -----
// Checker for the two-layer sprite blitter: watches the request, result and register
// channels, keeps its own copy of both layers, flags and palette, and compares results.
// Depends on tsb_pkg for the request and result types, function codes and blend table.
module two_layer_sprite_blitter_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  tsb_pkg::req_t  in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  tsb_pkg::rsp_t  out_data,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output int             errors,
	output int             pending,
	output int             checked
);

	localparam int LAYER_CELLS = 512 * 512;

	logic [1:0]     fg_mem [LAYER_CELLS];
	logic [1:0]     bg_mem [LAYER_CELLS];
	logic           fg_dirty, bg_dirty;
	logic [9:0]     width_reg, height_reg;
	logic [15:0]    red_reg, green_reg, blue_reg;
	tsb_pkg::rsp_t  expected_rsp [$];

	assign pending = expected_rsp.size();

	function automatic int active_width();
		return (width_reg > 512) ? 512 : int'(width_reg);
	endfunction

	function automatic int active_height();
		return (height_reg > 512) ? 512 : int'(height_reg);
	endfunction

	function automatic void store_pixel(logic sel, logic [15:0] x, logic [15:0] y,
			logic [1:0] val);
		int w, h, idx;
		w = active_width();
		h = active_height();
		if (x >= w || y >= h)
			return;
		idx = x + y * w;
		if (sel) begin
			if (fg_mem[idx] != val) begin
				fg_mem[idx] = val;
				fg_dirty = 1'b1;
			end
		end else begin
			if (bg_mem[idx] != val) begin
				bg_mem[idx] = val;
				bg_dirty = 1'b1;
			end
		end
	endfunction

	function automatic logic [11:0] palette_color(logic [1:0] entry);
		int sh;
		sh = 12 - 4 * entry;
		return {red_reg[sh +: 4], green_reg[sh +: 4], blue_reg[sh +: 4]};
	endfunction

	function automatic void draw_sprite(tsb_pkg::req_t r);
		logic [7:0]  row_lo, row_hi;
		logic [1:0]  code;
		logic        opaque;
		logic [15:0] px, py;
		opaque = tsb_pkg::BLEND_TAB[4][r.color] != 2'd0;
		for (int v = 0; v < 8; v++) begin
			row_lo = r.sprite_plane_low[8*v +: 8];
			row_hi = r.two_bpp ? r.sprite_plane_high[8*v +: 8] : 8'd0;
			for (int c = 0; c < 8; c++) begin
				code = {row_hi[7-c], row_lo[7-c]};
				if (opaque || code != 2'd0) begin
					px = r.x_pos + 16'(r.flip_x ? 7 - c : c);
					py = r.y_pos + 16'(r.flip_y ? 7 - v : v);
					store_pixel(r.layer_select, px, py, tsb_pkg::BLEND_TAB[code][r.color]);
				end
			end
		end
	endfunction

	function automatic tsb_pkg::rsp_t apply_request(tsb_pkg::req_t r);
		tsb_pkg::rsp_t res;
		int w, h, idx;
		logic [1:0] f, b;
		res = '0;
		w = active_width();
		h = active_height();
		case (r.func)
			tsb_pkg::FN_PLOT: store_pixel(r.layer_select, r.x_pos, r.y_pos, r.color[1:0]);
			tsb_pkg::FN_BLIT: draw_sprite(r);
			tsb_pkg::FN_CLEAR: begin
				for (int i = 0; i < w * h; i++) begin
					if (r.layer_select)
						fg_mem[i] = 2'd0;
					else
						bg_mem[i] = 2'd0;
				end
				if (r.layer_select)
					fg_dirty = 1'b1;
				else
					bg_dirty = 1'b1;
			end
			tsb_pkg::FN_READ: begin
				if (r.x_pos < w && r.y_pos < h) begin
					idx = r.x_pos + r.y_pos * w;
					f = fg_mem[idx];
					b = bg_mem[idx];
					res.composed_index = {f, b};
					res.pixel_rgb = palette_color(f != 2'd0 ? f : b);
				end
			end
			tsb_pkg::FN_ACK: begin
				fg_dirty = 1'b0;
				bg_dirty = 1'b0;
			end
			default: ;
		endcase
		res.fg_changed = fg_dirty;
		res.bg_changed = bg_dirty;
		return res;
	endfunction

	task automatic report(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	initial begin
		errors = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		tsb_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < LAYER_CELLS; i++) begin
				fg_mem[i] = 2'd0;
				bg_mem[i] = 2'd0;
			end
			fg_dirty = 1'b0;
			bg_dirty = 1'b0;
			width_reg = 10'd512;
			height_reg = 10'd512;
			red_reg = '0;
			green_reg = '0;
			blue_reg = '0;
			expected_rsp.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_rsp.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					want = expected_rsp.pop_front();
					checked++;
					if (out_data.composed_index !== want.composed_index)
						report($sformatf("composed_index %0d, want %0d",
							out_data.composed_index, want.composed_index));
					if (out_data.pixel_rgb !== want.pixel_rgb)
						report($sformatf("pixel_rgb %h, want %h",
							out_data.pixel_rgb, want.pixel_rgb));
					if (out_data.fg_changed !== want.fg_changed)
						report($sformatf("fg_changed %b, want %b",
							out_data.fg_changed, want.fg_changed));
					if (out_data.bg_changed !== want.bg_changed)
						report($sformatf("bg_changed %b, want %b",
							out_data.bg_changed, want.bg_changed));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tsb_pkg::CFG_WIDTH: width_reg = cfg_data[9:0];
					tsb_pkg::CFG_HEIGHT: height_reg = cfg_data[9:0];
					tsb_pkg::CFG_RED, tsb_pkg::CFG_GREEN, tsb_pkg::CFG_BLUE: begin
						if (cfg_index == tsb_pkg::CFG_RED)
							red_reg = cfg_data;
						else if (cfg_index == tsb_pkg::CFG_GREEN)
							green_reg = cfg_data;
						else
							blue_reg = cfg_data;
						fg_dirty = 1'b1;
						bg_dirty = 1'b1;
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_rsp.push_back(apply_request(in_data));
		end
	end
endmodule

// ----- verif/two_layer_sprite_blitter_top_tb.sv -----
// Testbench top for the two-layer sprite blitter: drives requests and register writes
// through several screen and palette settings with random idling, and gives the verdict.
// Depends on tsb_pkg, two_layer_sprite_blitter_top and two_layer_sprite_blitter_checker.
module two_layer_sprite_blitter_top_tb;

	localparam logic [2:0] FN_SPARE = 3'd5;
	localparam int CYCLE_LIMIT = 3000000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	tsb_pkg::req_t  in_data = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	tsb_pkg::rsp_t  out_data;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [2:0]     cfg_index = '0;
	logic [15:0]    cfg_data = '0;
	int             errors, pending, checked;
	int             cycles = 0;
	int             sent = 0;
	int             op_count [8];
	logic           calm = 1'b0;
	int             scr_w = 512, scr_h = 512;

	two_layer_sprite_blitter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	two_layer_sprite_blitter_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_stall <= !calm && ($urandom_range(99) < 34);
		if (cycles >= CYCLE_LIMIT) begin
			$display("two_layer_sprite_blitter_top regression: fail");
			$finish;
		end
	end

	task automatic send_request(tsb_pkg::req_t r);
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sent++;
		op_count[r.func]++;
		if (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		@(posedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_screen(int w, int h, logic [15:0] r, logic [15:0] g, logic [15:0] b);
		drain();
		write_reg(tsb_pkg::CFG_WIDTH, 16'(w));
		write_reg(tsb_pkg::CFG_HEIGHT, 16'(h));
		write_reg(tsb_pkg::CFG_RED, r);
		write_reg(tsb_pkg::CFG_GREEN, g);
		write_reg(tsb_pkg::CFG_BLUE, b);
		cfg_valid <= 1'b0;
		scr_w = (w > 512) ? 512 : w;
		scr_h = (h > 512) ? 512 : h;
	endtask

	function automatic logic [15:0] pick_coord(int lim);
		int k;
		k = $urandom_range(99);
		if (k < 45)
			return 16'($urandom_range(lim + 1));
		else if (k < 65)
			return 16'($urandom_range(31));
		else if (k < 80)
			return 16'hFFFF - 16'($urandom_range(9));
		return 16'($urandom);
	endfunction

	function automatic tsb_pkg::req_t random_request();
		tsb_pkg::req_t r;
		int k;
		r = '0;
		r.layer_select = 1'($urandom_range(1));
		r.x_pos = pick_coord(scr_w);
		r.y_pos = pick_coord(scr_h);
		r.sprite_plane_low = {$urandom, $urandom};
		r.sprite_plane_high = {$urandom, $urandom};
		r.color = 4'($urandom_range(15));
		r.flip_x = 1'($urandom_range(1));
		r.flip_y = 1'($urandom_range(1));
		r.two_bpp = 1'($urandom_range(1));
		k = $urandom_range(99);
		if (k < 25)
			r.func = tsb_pkg::FN_PLOT;
		else if (k < 52)
			r.func = tsb_pkg::FN_BLIT;
		else if (k < 88)
			r.func = tsb_pkg::FN_READ;
		else if (k < 94)
			r.func = tsb_pkg::FN_ACK;
		else if (k < 97 && scr_w * scr_h <= 4096)
			r.func = tsb_pkg::FN_CLEAR;
		else if (k < 97)
			r.func = tsb_pkg::FN_READ;
		else
			r.func = FN_SPARE + 3'($urandom_range(2));
		return r;
	endfunction

	task automatic directed_part();
		tsb_pkg::req_t r;
		r = '0;
		r.func = tsb_pkg::FN_PLOT; r.layer_select = 1'b1; r.color = 4'd7;
		send_request(r);
		r.x_pos = 16'd511; r.y_pos = 16'd511; r.layer_select = 1'b0; r.color = 4'd2;
		send_request(r);
		r.x_pos = 16'd512; r.color = 4'd1;
		send_request(r);
		r.func = tsb_pkg::FN_READ; r.x_pos = 16'd0; r.y_pos = 16'd0;
		send_request(r);
		r.x_pos = 16'd511; r.y_pos = 16'd511;
		send_request(r);
		r.func = tsb_pkg::FN_ACK;
		send_request(r);
		r.func = tsb_pkg::FN_BLIT; r.x_pos = 16'hFFFC; r.y_pos = 16'hFFFD;
		r.sprite_plane_low = '1; r.sprite_plane_high = '1; r.two_bpp = 1'b1;
		for (int m = 0; m < 16; m += 3) begin
			r.color = 4'(m);
			r.flip_x = m[0];
			r.flip_y = m[1];
			r.layer_select = m[2];
			send_request(r);
		end
		r.func = tsb_pkg::FN_BLIT; r.x_pos = 16'd2; r.y_pos = 16'd3; r.two_bpp = 1'b0;
		r.sprite_plane_low = 64'h8142_2418_1824_4281; r.color = 4'd15;
		send_request(r);
		r.func = tsb_pkg::FN_READ; r.x_pos = 16'd2; r.y_pos = 16'd3;
		send_request(r);
		r.func = FN_SPARE;
		send_request(r);
		r.func = 3'd7;
		send_request(r);
		r.func = tsb_pkg::FN_CLEAR; r.layer_select = 1'b1;
		send_request(r);
		r.func = tsb_pkg::FN_READ; r.x_pos = 16'd1; r.y_pos = 16'd0;
		send_request(r);
	endtask

	initial begin
		int widths [6]  = '{512, 1, 16, 0, 1023, 40};
		int heights [6] = '{512, 1, 12, 5, 700, 30};
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		directed_part();
		for (int p = 0; p < 6; p++) begin
			if (p == 0)
				set_screen(widths[p], heights[p], 16'h0000, 16'hFFFF, 16'h0F5A);
			else
				set_screen(widths[p], heights[p], 16'($urandom),
					(p == 1) ? 16'hFFFF : 16'($urandom), 16'($urandom));
			calm <= (p == 2);
			for (int i = 0; i < 155; i++) begin
				if (i == 80) begin
					drain();
				end
				send_request(random_request());
			end
			calm <= 1'b0;
		end
		drain();
		repeat (100) @(posedge clk);
		$display("Sent %0d requests over six screen settings (%0d plots, %0d blits,",
			sent, op_count[tsb_pkg::FN_PLOT], op_count[tsb_pkg::FN_BLIT]);
		$display("  %0d clears, %0d reads, %0d acknowledges); %0d results checked.",
			op_count[tsb_pkg::FN_CLEAR], op_count[tsb_pkg::FN_READ],
			op_count[tsb_pkg::FN_ACK], checked);
		if (errors == 0)
			$display("two_layer_sprite_blitter_top regression: pass");
		else
			$display("two_layer_sprite_blitter_top regression: fail");
		$finish;
	end
endmodule
